@@ sv/kvt_pkg.sv @@
// Shared types, constants and helper functions of the key/value text tokenizer.
package kvt_pkg;

  localparam int unsigned OFFSET_BITS = 24;
  localparam int unsigned FIELD_BITS  = 24;
  localparam int unsigned LINE_BITS   = 16;

  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_DIGIT0 = 8'h30;
  localparam logic [7:0] CH_DIGIT9 = 8'h39;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;

  typedef enum logic [2:0] {
    ST_SPACE   = 3'd0,
    ST_KEY     = 3'd1,
    ST_GAP     = 3'd2,
    ST_QUOTED  = 3'd3,
    ST_ESCAPE  = 3'd4,
    ST_VALUE   = 3'd5,
    ST_COMMENT = 3'd6
  } parse_state_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BAD_CHAR = 2'd1,
    ERR_EMPTY    = 2'd2
  } err_code_e;

  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [LINE_BITS-1:0]   line_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       first_byte;
    logic       last_byte;
  } kvt_in_t;

  typedef struct packed {
    logic                  pair_valid;
    logic [FIELD_BITS-1:0] key_start;
    logic [FIELD_BITS-1:0] key_length;
    logic [FIELD_BITS-1:0] value_start;
    logic [FIELD_BITS-1:0] value_length;
    logic [1:0]            error_code;
    logic [LINE_BITS-1:0]  error_line;
    logic [LINE_BITS-1:0]  error_column;
    logic                  stream_done;
  } kvt_out_t;

  typedef struct packed {
    parse_state_e parse_state;
    offset_t      byte_offset;
    line_t        line_count;
    line_t        column_count;
    offset_t      key_first_offset;
    offset_t      key_end_offset;
    offset_t      value_first_offset;
    logic         halted;
  } kvt_state_t;

  localparam kvt_state_t STATE_RESET = '{
    parse_state:        ST_SPACE,
    byte_offset:        '0,
    line_count:         line_t'(1),
    column_count:       line_t'(1),
    key_first_offset:   '0,
    key_end_offset:     '0,
    value_first_offset: '0,
    halted:             1'b0
  };

  // Letters of either case, digits, dot, dash and underscore may form a key.
  function automatic logic is_key_char(input logic [7:0] c);
    logic [7:0] low;
    low = c | CH_SPACE;
    return (low inside {[CH_LOW_A:CH_LOW_Z]}) || (c inside {[CH_DIGIT0:CH_DIGIT9]}) ||
           (c inside {CH_DOT, CH_DASH, CH_UNDER});
  endfunction

  function automatic logic [FIELD_BITS-1:0] to_field(input offset_t off);
    return FIELD_BITS'(off);
  endfunction

endpackage

@@ sv/kvt_core.sv @@
// Parser state registers and the combinational update that handles one byte.
module kvt_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  kvt_pkg::kvt_in_t  item_i,
  output kvt_pkg::kvt_out_t result_o
);
  import kvt_pkg::*;

  kvt_state_t st_q, st_d, cur;
  offset_t    here, here_next, klen, vlen;
  logic       pair, pair_ok, newline, stop;
  err_code_e  err;

  always_comb begin
    cur = item_i.first_byte ? STATE_RESET : st_q;
    st_d = cur;
    here = cur.byte_offset;
    here_next = here + offset_t'(1);
    klen = cur.key_end_offset - cur.key_first_offset;
    vlen = here - cur.value_first_offset;
    pair = 1'b0;
    pair_ok = 1'b0;
    newline = 1'b0;
    err = ERR_NONE;

    case (cur.parse_state)
      ST_KEY: begin
        if (is_key_char(item_i.byte_value)) begin
          st_d.parse_state = ST_KEY;
        end else if (item_i.byte_value inside {CH_SPACE, CH_TAB}) begin
          st_d.key_end_offset = here;
          st_d.parse_state = ST_GAP;
        end else begin
          err = ERR_BAD_CHAR;
        end
      end
      ST_GAP: begin
        if (item_i.byte_value inside {CH_SPACE, CH_TAB}) begin
          st_d.parse_state = ST_GAP;
        end else if (item_i.byte_value == CH_QUOTE) begin
          st_d.value_first_offset = here_next;
          st_d.parse_state = ST_QUOTED;
        end else begin
          st_d.value_first_offset = here;
          st_d.parse_state = ST_VALUE;
        end
      end
      ST_QUOTED: begin
        if (item_i.byte_value == CH_QUOTE) begin
          pair = 1'b1;
        end else if (item_i.byte_value == CH_BSLASH) begin
          st_d.parse_state = ST_ESCAPE;
        end else if (item_i.byte_value == CH_NL) begin
          newline = 1'b1;
        end
      end
      ST_ESCAPE: begin
        if (item_i.byte_value != CH_BSLASH) begin
          newline = (item_i.byte_value == CH_NL);
          st_d.parse_state = ST_QUOTED;
        end
      end
      ST_VALUE: begin
        if (item_i.byte_value == CH_NL) begin
          pair = 1'b1;
          newline = 1'b1;
        end
      end
      ST_COMMENT: begin
        if (item_i.byte_value == CH_NL) begin
          newline = 1'b1;
          st_d.parse_state = ST_SPACE;
        end
      end
      default: begin
        if (item_i.byte_value == CH_NL) begin
          newline = 1'b1;
        end else if (item_i.byte_value inside {CH_SPACE, CH_CR}) begin
          st_d.parse_state = cur.parse_state;
        end else if (item_i.byte_value == CH_HASH) begin
          st_d.parse_state = ST_COMMENT;
        end else if (is_key_char(item_i.byte_value)) begin
          st_d.key_first_offset = here;
          st_d.parse_state = ST_KEY;
        end else begin
          err = ERR_BAD_CHAR;
        end
      end
    endcase

    if (pair) begin
      if (klen == '0 || vlen == '0) begin
        err = ERR_EMPTY;
      end else begin
        pair_ok = 1'b1;
        st_d.parse_state = ST_SPACE;
      end
    end

    stop = (err != ERR_NONE);
    if (stop) begin
      st_d.halted = 1'b1;
    end else begin
      st_d.byte_offset = here_next;
      if (newline) begin
        if (cur.line_count != LINE_MAX) begin
          st_d.line_count = cur.line_count + line_t'(1);
        end
        st_d.column_count = line_t'(1);
      end else if (cur.column_count != LINE_MAX) begin
        st_d.column_count = cur.column_count + line_t'(1);
      end
    end

    // A halted parser ignores the byte entirely.
    if (cur.halted) begin
      st_d = cur;
    end
  end

  always_comb begin
    result_o = '0;
    result_o.stream_done = item_i.last_byte;
    if (!cur.halted) begin
      if (pair_ok) begin
        result_o.pair_valid = 1'b1;
        result_o.key_start = to_field(cur.key_first_offset);
        result_o.key_length = to_field(klen);
        result_o.value_start = to_field(cur.value_first_offset);
        result_o.value_length = to_field(vlen);
      end
      if (stop) begin
        result_o.error_code = err;
        result_o.error_line = cur.line_count;
        result_o.error_column = cur.column_count;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= STATE_RESET;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

endmodule

@@ sv/kvt_out_reg.sv @@
// Result register that holds a finished item until the downstream side takes it.
module kvt_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  kvt_pkg::kvt_out_t result_i,
  input  logic              stall_i,
  output logic              valid_o,
  output kvt_pkg::kvt_out_t result_o
);
  import kvt_pkg::*;

  logic     valid_q, valid_d;
  kvt_out_t data_q;

  assign valid_d = load_i | (valid_q & stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = data_q;

endmodule

@@ sv/key_value_text_tokenizer.sv @@
// Top level of the key/value text tokenizer: input register, parser and result register.
//
// The block reads a text file one byte per item and reports "key value" pairs as byte
// offset spans, one result item for every input item. It takes one byte every clock
// cycle while the result side is not stalled. A byte accepted at a clock edge is held
// in the input register, the parser handles it with short combinational logic and
// its result is captured in the result register when the held byte moves on, after
// which the result item is offered downstream. These are the two register stages; a
// stalled result holds the byte behind it, and the input stalls only when both stages
// are full. Raise first_byte on the opening byte of each file to restart the offset,
// line and column counts. After a bad character or an empty key or value the error is
// reported once, with its line and column, and every later byte yields a result
// carrying only stream_done until the next first byte. Offsets wrap modulo the offset
// width, and line and column stop at their maximum. A plain value with no closing
// newline, or an unterminated quote, gives no pair at the end of the file.
module key_value_text_tokenizer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  kvt_pkg::kvt_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output kvt_pkg::kvt_out_t out_item_o
);
  import kvt_pkg::*;

  logic     in_valid_q, in_valid_d;
  kvt_in_t  in_item_q;
  logic     advance;
  kvt_out_t step_result;

  // The held byte moves on whenever the result register is empty or being emptied.
  assign advance    = in_valid_q & (~out_valid_o | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~advance;
  assign in_valid_d = in_stall_o ? in_valid_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
  end

  kvt_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_item_q),
    .result_o (step_result)
  );

  kvt_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .result_i (step_result),
    .stall_i  (out_stall_i),
    .valid_o  (out_valid_o),
    .result_o (out_item_o)
  );

  // The input side is only held back when both registers are occupied.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_o))
    else $error("input stalled while a register stage was free");

  // A result never reports a pair and an error together.
  a_pair_xor_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.pair_valid && out_item_o.error_code != ERR_NONE))
    else $error("pair and error reported on the same item");

  // Every byte that leaves the input register arrives as a result with its end marker.
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_valid_o && out_item_o.stream_done == $past(in_item_q.last_byte)))
    else $error("result lost or end marker mismatched");

  // An error always carries a real line and column.
  a_error_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.error_code != ERR_NONE) |->
      (out_item_o.error_line != '0 && out_item_o.error_column != '0))
    else $error("error reported without a position");

endmodule

@@ bench/tb_key_value_text_tokenizer.sv @@
// Self-checking testbench of the key/value text tokenizer with its own span predictor.
`timescale 1ns / 100ps

module tb_key_value_text_tokenizer;
  import kvt_pkg::*;

  // Random stimulus size, the long receiver hold-off and the run limit. The limit
  // covers the whole stimulus, each byte facing the longest sender gap and the
  // longest short receiver stall, many times over, together with the long hold-off.
  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned TAIL_CYCLES  = 10;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned RUN_LIMIT_NS = 2_000_000;

  localparam string NAME_POOL =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.-_";

  // Tracks the parser exactly as the block should, one byte at a time, and keeps the
  // results still owed by the block in arrival order.
  class span_checker;
    kvt_out_t     expected_spans[$];
    int unsigned  mismatches;
    parse_state_e state;
    offset_t      offset_now;
    offset_t      key_first;
    offset_t      key_end;
    offset_t      value_first;
    line_t        line_no;
    line_t        column_no;
    bit           halted;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      state       = ST_SPACE;
      offset_now  = '0;
      key_first   = '0;
      key_end     = '0;
      value_first = '0;
      line_no     = line_t'(1);
      column_no   = line_t'(1);
      halted      = 1'b0;
    endfunction

    static function bit is_name_char(logic [7:0] c);
      logic [7:0] folded;
      folded = c | CH_SPACE;
      return (folded >= CH_LOW_A && folded <= CH_LOW_Z) ||
             (c >= CH_DIGIT0 && c <= CH_DIGIT9) ||
             c == CH_DOT || c == CH_DASH || c == CH_UNDER;
    endfunction

    static function string format_span(kvt_out_t r);
      return $sformatf("pair=%0d key=%0d+%0d value=%0d+%0d err=%0d at %0d:%0d done=%0d",
                       r.pair_valid, r.key_start, r.key_length, r.value_start,
                       r.value_length, r.error_code, r.error_line, r.error_column,
                       r.stream_done);
    endfunction

    // Works out the result of one accepted byte and queues it.
    function void note_byte(kvt_in_t item);
      kvt_out_t   res;
      offset_t    here;
      offset_t    key_len;
      offset_t    value_len;
      logic [7:0] c;
      bit         line_end;
      bit         pair_done;
      err_code_e  fault;
      res       = '0;
      c         = item.byte_value;
      line_end  = 1'b0;
      pair_done = 1'b0;
      fault     = ERR_NONE;
      res.stream_done = item.last_byte;
      if (item.first_byte) restart();
      if (!halted) begin
        here = offset_now;
        case (state)
          ST_KEY: begin
            if (!is_name_char(c)) begin
              if (c == CH_SPACE || c == CH_TAB) begin
                key_end = here;
                state   = ST_GAP;
              end else begin
                fault = ERR_BAD_CHAR;
              end
            end
          end
          ST_GAP: begin
            if (c == CH_QUOTE) begin
              value_first = here + offset_t'(1);
              state       = ST_QUOTED;
            end else if (c != CH_SPACE && c != CH_TAB) begin
              // A newline here opens a plain value and is not counted as a line.
              value_first = here;
              state       = ST_VALUE;
            end
          end
          ST_QUOTED: begin
            if (c == CH_QUOTE) pair_done = 1'b1;
            else if (c == CH_BSLASH) state = ST_ESCAPE;
            else if (c == CH_NL) line_end = 1'b1;
          end
          ST_ESCAPE: begin
            // A run of backslashes keeps the escape open.
            if (c != CH_BSLASH) begin
              line_end = (c == CH_NL);
              state    = ST_QUOTED;
            end
          end
          ST_VALUE: begin
            if (c == CH_NL) begin
              pair_done = 1'b1;
              line_end  = 1'b1;
            end
          end
          ST_COMMENT: begin
            if (c == CH_NL) begin
              line_end = 1'b1;
              state    = ST_SPACE;
            end
          end
          default: begin
            if (c == CH_NL) begin
              line_end = 1'b1;
            end else if (c != CH_SPACE && c != CH_CR) begin
              if (c == CH_HASH) begin
                state = ST_COMMENT;
              end else if (is_name_char(c)) begin
                key_first = here;
                state     = ST_KEY;
              end else begin
                fault = ERR_BAD_CHAR;
              end
            end
          end
        endcase
        if (pair_done) begin
          key_len   = key_end - key_first;
          value_len = here - value_first;
          if (key_len == '0 || value_len == '0) begin
            fault = ERR_EMPTY;
          end else begin
            res.pair_valid   = 1'b1;
            res.key_start    = key_first;
            res.key_length   = key_len;
            res.value_start  = value_first;
            res.value_length = value_len;
            state            = ST_SPACE;
          end
        end
        if (fault != ERR_NONE) begin
          // The error is reported at the position of the offending byte, after which
          // the parser ignores everything until the next first byte.
          res.error_code   = fault;
          res.error_line   = line_no;
          res.error_column = column_no;
          halted           = 1'b1;
        end else begin
          offset_now = here + offset_t'(1);
          if (line_end) begin
            if (line_no != LINE_MAX) line_no++;
            column_no = line_t'(1);
          end else if (column_no != LINE_MAX) begin
            column_no++;
          end
        end
      end
      expected_spans.push_back(res);
    endfunction

    function void check_result(kvt_out_t got);
      kvt_out_t want;
      bit       wrong;
      if (expected_spans.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("unexpected result: %s", format_span(got));
        return;
      end
      want  = expected_spans.pop_front();
      wrong = (got.pair_valid   !== want.pair_valid)   ||
              (got.key_start    !== want.key_start)    ||
              (got.key_length   !== want.key_length)   ||
              (got.value_start  !== want.value_start)  ||
              (got.value_length !== want.value_length) ||
              (got.error_code   !== want.error_code)   ||
              (got.error_line   !== want.error_line)   ||
              (got.error_column !== want.error_column) ||
              (got.stream_done  !== want.stream_done);
      if (wrong) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("mismatch at %0t: expected %s", $time, format_span(want));
          $display("              actual   %s", format_span(got));
        end
      end
    endfunction
  endclass

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  kvt_in_t  in_item   = '0;
  logic     out_stall = 1'b0;
  logic     in_stall;
  logic     out_valid;
  kvt_out_t out_item;

  span_checker spans = new();

  // Bytes of the file being assembled, the sender's burst budget and the count of
  // long receiver hold-offs asked for by the stimulus and served by the receiver.
  logic [7:0]  file_bytes[$];
  int unsigned burst_left   = 0;
  int unsigned holds_asked  = 0;
  int unsigned holds_served = 0;

  key_value_text_tokenizer u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Offers one item and returns in the time step of its acceptance. Between bursts
  // of random length the sender sometimes drops valid for a random gap; a burst is
  // sometimes long so that stretches without any gap occur as well.
  task automatic offer_byte(input kvt_in_t item);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      gap        = $urandom_range(0, 4);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_item  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    spans.note_byte(item);
  endtask

  // Sends the assembled file with first_byte on its opening byte and last_byte on its
  // closing byte.
  task automatic send_file();
    kvt_in_t item;
    foreach (file_bytes[i]) begin
      item.byte_value = file_bytes[i];
      item.first_byte = (i == 0);
      item.last_byte  = (i == file_bytes.size() - 1);
      offer_byte(item);
    end
    file_bytes.delete();
  endtask

  task automatic wait_for_results();
    while (spans.expected_spans.size() != 0) @(posedge clk);
  endtask

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) file_bytes.push_back(s[i]);
  endfunction

  function automatic logic [7:0] any_byte_except(logic [7:0] a, logic [7:0] b);
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == a || v == b);
    return v;
  endfunction

  // A byte that breaks the line: in blank space anything that cannot start a key, a
  // comment or blank space; inside a key anything that can neither extend nor end it.
  function automatic logic [7:0] pick_bad_byte(bit in_key);
    logic [7:0] v;
    bit         harmless;
    do begin
      v = 8'($urandom_range(0, 255));
      if (in_key) harmless = span_checker::is_name_char(v) || v == CH_SPACE || v == CH_TAB;
      else harmless = span_checker::is_name_char(v) || v == CH_SPACE || v == CH_CR ||
                      v == CH_NL || v == CH_HASH;
    end while (harmless);
    return v;
  endfunction

  function automatic void put_key();
    repeat ($urandom_range(1, 6))
      file_bytes.push_back(NAME_POOL[$urandom_range(0, NAME_POOL.len() - 1)]);
  endfunction

  function automatic void put_gap();
    repeat ($urandom_range(1, 3)) file_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endfunction

  // One line of a file: a comment, a blank line, a plain pair, a pair whose value
  // opens with the newline straight after the gap, or a quoted pair with escapes.
  // A broken line carries a bad character or an empty quoted value.
  function automatic void put_line(bit broken);
    int unsigned kind;
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) file_bytes.push_back(CH_SPACE);
    if (broken) begin
      case ($urandom_range(0, 2))
        0: file_bytes.push_back(pick_bad_byte(1'b0));
        1: begin
          put_key();
          file_bytes.push_back(pick_bad_byte(1'b1));
        end
        default: begin
          put_key();
          put_gap();
          file_bytes.push_back(CH_QUOTE);
          file_bytes.push_back(CH_QUOTE);
        end
      endcase
      return;
    end
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      file_bytes.push_back(CH_HASH);
      repeat ($urandom_range(0, 10)) file_bytes.push_back(any_byte_except(CH_NL, CH_NL));
      file_bytes.push_back(CH_NL);
    end else if (kind == 1) begin
      if ($urandom_range(0, 1)) file_bytes.push_back(CH_CR);
      file_bytes.push_back(CH_NL);
    end else begin
      put_key();
      put_gap();
      if (kind <= 5) begin
        if (kind == 5) file_bytes.push_back(CH_NL);
        repeat ($urandom_range(1, 8)) file_bytes.push_back(any_byte_except(CH_NL, CH_NL));
        file_bytes.push_back(CH_NL);
      end else begin
        file_bytes.push_back(CH_QUOTE);
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 3) == 0) begin
            file_bytes.push_back(CH_BSLASH);
            file_bytes.push_back(8'($urandom_range(0, 255)));
          end else begin
            file_bytes.push_back(any_byte_except(CH_QUOTE, CH_BSLASH));
          end
        end
        file_bytes.push_back(CH_QUOTE);
        if ($urandom_range(0, 1)) file_bytes.push_back(CH_NL);
      end
    end
  endfunction

  // Receiver: takes results whenever it does not stall, alternating short stall and
  // free stretches, with an occasional long free stretch. When the stimulus asks for
  // a long hold-off it stalls long enough for the block to fill up and push back on
  // its input.
  initial begin : receiver
    int unsigned run_left;
    bit          stalling;
    run_left = 0;
    stalling = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) spans.check_result(out_item);
      if (holds_asked != holds_served) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        holds_served++;
        out_stall <= 1'b0;
      end else begin
        if (run_left == 0) begin
          stalling = !stalling;
          if (stalling) run_left = $urandom_range(1, 4);
          else run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 12);
        end
        run_left--;
        out_stall <= stalling;
      end
    end
  end

  initial begin : stimulus
    kvt_in_t     item;
    int unsigned random_sent;
    int unsigned lines;
    bit          paused;
    random_sent = 0;
    paused      = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A key ended by a tab with a value opened by an uncounted newline.
    put_text("a\t\nx\n");
    send_file();
    // A carriage return, a comment and a quoted value holding 0xFF and an escaped quote.
    put_text("\015#\nk \"\377\\\"\"\n");
    send_file();
    // An empty quoted value, then a byte that the halted parser ignores.
    put_text("z \"\"y");
    send_file();
    // A NUL in blank space is a bad character.
    file_bytes.push_back(8'h00);
    send_file();
    // A plain value cut off by the end of the file gives no pair.
    put_text("k v");
    send_file();
    in_valid <= 1'b0;
    wait_for_results();

    // Mostly well-formed files with random content, some ending in a broken line or
    // without their closing newline, mixed with streams of raw noise.
    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(4, 16)) begin
          item.byte_value = 8'($urandom_range(0, 255));
          item.first_byte = ($urandom_range(0, 5) == 0);
          item.last_byte  = ($urandom_range(0, 5) == 0);
          offer_byte(item);
        end
      end else begin
        lines = $urandom_range(1, 5);
        repeat (lines) put_line(1'b0);
        if ($urandom_range(0, 6) == 0) put_line(1'b1);
        else if ($urandom_range(0, 6) == 0 && file_bytes[$] == CH_NL) void'(file_bytes.pop_back());
        random_sent += file_bytes.size();
        send_file();
      end
      if (holds_asked == 0 && random_sent >= RANDOM_ITEMS / 3) holds_asked++;
      if (!paused && random_sent >= (2 * RANDOM_ITEMS) / 3) begin
        in_valid <= 1'b0;
        wait_for_results();
        paused = 1'b1;
      end
    end

    in_valid <= 1'b0;
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (spans.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule
